// ----- sv/pcg_pkg.sv -----
package pcg_pkg;

  localparam int SINE_TABLE_BITS = 10;
  localparam int SINE_OUT_BITS   = 16;
  localparam int TBL_N           = 1 << SINE_TABLE_BITS;

  localparam int POS_W    = 32;
  localparam int ANGLE_W  = 34;
  localparam int KCONST_W = 17;
  localparam int INV_W    = 30;
  localparam int PHASE_W  = 32;
  localparam int FRAC_W   = 16;
  localparam int U16_W    = 18;
  localparam int SUM_W    = 19;
  localparam int CHAN_W   = 16;

  localparam int PROD_RND = 32768;
  localparam int SUM_BIAS = 131072;

  localparam logic [INV_W-1:0] INV_TURN = 30'd683565276;

  localparam logic [KCONST_W-1:0] K_RED_MIX = 17'd15401;
  localparam logic [KCONST_W-1:0] K_GRN_X   = 17'd22086;
  localparam logic [KCONST_W-1:0] K_GRN_Y   = 17'd17236;
  localparam logic [KCONST_W-1:0] K_GRN_MIX = 17'd53805;
  localparam logic [KCONST_W-1:0] K_GRN_T   = 17'd47251;
  localparam logic [KCONST_W-1:0] K_BLU_X   = 17'd5446;
  localparam logic [KCONST_W-1:0] K_BLU_Y   = 17'd4791;
  localparam logic [KCONST_W-1:0] K_BLU_MIX = 17'd81179;
  localparam logic [KCONST_W-1:0] K_BLU_T   = 17'd15532;

  localparam int SINE_ONE = 1 << SINE_OUT_BITS;
  localparam int SINE_SHR = (SINE_OUT_BITS > 16) ? SINE_OUT_BITS - 16 : 0;
  localparam int SINE_SHL = (SINE_OUT_BITS < 16) ? 16 - SINE_OUT_BITS : 0;
  localparam int SINE_RND = (SINE_OUT_BITS > 16) ? 1 << (SINE_OUT_BITS - 17) : 0;
  localparam int CONV_W   = (SINE_OUT_BITS + 2 > U16_W) ? SINE_OUT_BITS + 2 : U16_W;

  typedef logic signed [POS_W-1:0]   pos_t;
  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic [KCONST_W-1:0]       kconst_t;
  typedef logic [PHASE_W-1:0]        phase_t;
  typedef logic [SINE_OUT_BITS:0]    sine_mag_t;
  typedef logic [U16_W-1:0]          u16_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic [CHAN_W-1:0]         chan_t;

  typedef struct packed {
    sum_t sum_b;
    sum_t sum_g;
    sum_t sum_r;
  } wave_sum_t;

  typedef struct packed {
    chan_t blue;
    chan_t green;
    chan_t red;
  } color_t;

  // Q16.16 product with round half up, floor semantics on negatives.
  function automatic angle_t mulq(angle_t a, kconst_t k);
    logic signed [ANGLE_W+KCONST_W:0] p;
    p = a * $signed({1'b0, k});
    p = p + $signed((ANGLE_W + KCONST_W + 1)'(PROD_RND));
    return p[ANGLE_W+FRAC_W-1:FRAC_W];
  endfunction

  // Angle in radians to a phase in 2^-32 turns, wrapping modulo one turn.
  function automatic phase_t phase_of(angle_t a);
    logic signed [ANGLE_W+INV_W:0] p;
    p = a * $signed({1'b0, INV_TURN});
    return p[FRAC_W+PHASE_W-1:FRAC_W];
  endfunction

  // Sine magnitude and sign to the offset value (sine + 1) in 16 fraction bits.
  function automatic u16_t sine_u16(sine_mag_t mag, logic neg);
    logic [CONV_W-1:0] u;
    if (neg) begin
      u = CONV_W'(SINE_ONE) - CONV_W'(mag);
    end else begin
      u = CONV_W'(SINE_ONE) + CONV_W'(mag);
    end
    u = ((u + CONV_W'(SINE_RND)) >> SINE_SHR) << SINE_SHL;
    return u[U16_W-1:0];
  endfunction

endpackage

// ----- sv/plasma_color_generator_top.sv -----
// Channel   Direction  Handshake                 Payload
// s_*       in         s_tvalid / s_tready       s_tdata: pos_x, pos_y
// m_*       out        m_tvalid / m_tready       m_tdata: red, green, blue
// APB       in         psel, penable, pwrite     frame_time at byte address 0
//
// One item is taken per clock while the output is not stalled: two rounds
// of constant multiply, phase multiply and registered sine table read set the depth.
// Synchronous rst clears the valid bits and frame_time; the sine table is constant.
// A stage holds its item while the stage after it is full and stalled, so bubbles
// close up and an item is accepted as long as any stage has room.
module plasma_color_generator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // pos_x [31:0], pos_y [63:32]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // red [15:0], green [31:16], blue [47:32]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pcg_pkg::*;

  localparam logic REG_FRAME_TIME = 1'b0;

  logic        frame_time_wr;
  logic [31:0] frame_time;
  logic        mid_valid;
  logic        mid_ready;
  wave_sum_t   sums;
  color_t      color;

  assign frame_time_wr = psel && penable && pwrite && (paddr[2] == REG_FRAME_TIME);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_time <= '0;
    end else if (frame_time_wr) begin
      frame_time <= pwdata;
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_FRAME_TIME: prdata = frame_time;
      default:        prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  pcg_wave_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .pos_x     (pos_t'(s_tdata[31:0])),
    .pos_y     (pos_t'(s_tdata[63:32])),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .sums      (sums)
  );

  pcg_wave_back u_back (
    .clk        (clk),
    .rst        (rst),
    .frame_time (frame_time),
    .in_valid   (mid_valid),
    .in_ready   (mid_ready),
    .sums       (sums),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .color      (color)
  );

  assign m_tdata = color;

endmodule

// ----- sv/pcg_sine_lookup.sv -----
module pcg_sine_lookup (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic [1:0]                            quad,
  input  logic [pcg_pkg::SINE_TABLE_BITS-1:0]   idx,
  output pcg_pkg::sine_mag_t                    mag,
  output logic                                  neg
);
  import pcg_pkg::*;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] TAYLOR_DIV [10] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342, 64'd420
  };

  typedef sine_mag_t sine_rom_t [TBL_N+1];

  // Quarter-wave table from a Q30 Taylor series, evaluated at elaboration.
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t          rom;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        v;
    logic signed [63:0] sum;
    for (int k = 0; k <= TBL_N; k++) begin
      x = (64'(k) * HALF_PI_Q30 + 64'(TBL_N / 2)) / 64'(TBL_N);
      x2 = (x * x) >> 30;
      term = x;
      sum = $signed(x);
      for (int m = 0; m < 10; m++) begin
        term = ((term * x2) >> 30) / TAYLOR_DIV[m];
        if ((m & 1) == 0) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum < 0) begin
        sum = '0;
      end
      v = (($unsigned(sum) << SINE_OUT_BITS) + (64'd1 << 29)) >> 30;
      if (v > (64'd1 << SINE_OUT_BITS)) begin
        v = 64'd1 << SINE_OUT_BITS;
      end
      rom[k] = v[SINE_OUT_BITS:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  logic [SINE_TABLE_BITS:0] addr;

  assign addr = quad[0] ? ((SINE_TABLE_BITS + 1)'(TBL_N) - {1'b0, idx}) : {1'b0, idx};

  always_ff @(posedge clk) begin
    if (en) begin
      mag <= SINE_ROM[addr];
      neg <= quad[1];
    end
  end

endmodule

// ----- sv/pcg_wave_front.sv -----
module pcg_wave_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  pcg_pkg::pos_t       pos_x,
  input  pcg_pkg::pos_t       pos_y,
  output logic                out_valid,
  input  logic                out_ready,
  output pcg_pkg::wave_sum_t  sums
);
  import pcg_pkg::*;

  localparam int STAGES = 4;
  localparam int LANES  = 6;
  // Lanes: sin x, cos y, cos(-0.337x), sin(0.263y), sin(0.0831x), cos(0.0731y).
  localparam logic [LANES-1:0] COS_LANE = 6'b100110;

  logic [STAGES-1:0]          vld;
  logic [STAGES-1:0]          en;
  pos_t                       ang  [LANES];
  phase_t                     ph   [LANES];
  logic [1:0]                 quad [LANES];
  logic [SINE_TABLE_BITS-1:0] idx  [LANES];
  sine_mag_t                  mag  [LANES];
  logic                       neg  [LANES];
  u16_t                       wave [LANES];

  always_comb begin
    en[STAGES-1] = !vld[STAGES-1] || out_ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ang[0] <= pos_x;
      ang[1] <= pos_y;
      ang[2] <= pos_t'(mulq(-angle_t'(pos_x), K_GRN_X));
      ang[3] <= pos_t'(mulq(angle_t'(pos_y), K_GRN_Y));
      ang[4] <= pos_t'(mulq(angle_t'(pos_x), K_BLU_X));
      ang[5] <= pos_t'(mulq(angle_t'(pos_y), K_BLU_Y));
    end
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      ph[i] = phase_of(angle_t'(ang[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < LANES; i++) begin
        quad[i] <= ph[i][PHASE_W-1 -: 2] + {1'b0, COS_LANE[i]};
        idx[i]  <= ph[i][PHASE_W-3 -: SINE_TABLE_BITS];
      end
    end
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lut
    pcg_sine_lookup u_lut (
      .clk  (clk),
      .en   (en[2]),
      .quad (quad[i]),
      .idx  (idx[i]),
      .mag  (mag[i]),
      .neg  (neg[i])
    );
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      wave[i] = sine_u16(mag[i], neg[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      sums.sum_r <= sum_t'(wave[0]) + sum_t'(wave[1]) - sum_t'(SUM_BIAS);
      sums.sum_g <= sum_t'(wave[2]) + sum_t'(wave[3]) - sum_t'(SUM_BIAS);
      sums.sum_b <= sum_t'(wave[4]) + sum_t'(wave[5]) - sum_t'(SUM_BIAS);
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[STAGES-1];

endmodule

// ----- sv/pcg_wave_back.sv -----
module pcg_wave_back (
  input  logic                clk,
  input  logic                rst,
  input  logic [31:0]         frame_time,
  input  logic                in_valid,
  output logic                in_ready,
  input  pcg_pkg::wave_sum_t  sums,
  output logic                out_valid,
  input  logic                out_ready,
  output pcg_pkg::color_t     color
);
  import pcg_pkg::*;

  localparam int STAGES = 5;
  localparam int LANES  = 3;
  // Lanes: red sine, green cosine, blue sine.
  localparam logic [LANES-1:0] COS_LANE = 3'b010;

  logic [STAGES-1:0]          vld;
  logic [STAGES-1:0]          en;
  sum_t                       mix  [LANES];
  logic [31:0]                t_grn;
  logic [31:0]                t_blu;
  angle_t                     ang  [LANES];
  phase_t                     ph   [LANES];
  logic [1:0]                 quad [LANES];
  logic [SINE_TABLE_BITS-1:0] idx  [LANES];
  sine_mag_t                  mag  [LANES];
  logic                       neg  [LANES];
  u16_t                       wave [LANES];

  always_comb begin
    en[STAGES-1] = !vld[STAGES-1] || out_ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      mix[0] <= sum_t'(mulq(angle_t'(sums.sum_r), K_RED_MIX));
      mix[1] <= sum_t'(mulq(angle_t'(sums.sum_g), K_GRN_MIX));
      mix[2] <= sum_t'(mulq(angle_t'(sums.sum_b), K_BLU_MIX));
      t_grn  <= 32'(mulq(angle_t'(frame_time), K_GRN_T));
      t_blu  <= 32'(mulq(angle_t'(frame_time), K_BLU_T));
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      ang[0] <= angle_t'(mix[0]) + angle_t'(frame_time);
      ang[1] <= angle_t'(mix[1]) + angle_t'(t_grn);
      ang[2] <= angle_t'(mix[2]) + angle_t'(t_blu);
    end
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      ph[i] = phase_of(ang[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int i = 0; i < LANES; i++) begin
        quad[i] <= ph[i][PHASE_W-1 -: 2] + {1'b0, COS_LANE[i]};
        idx[i]  <= ph[i][PHASE_W-3 -: SINE_TABLE_BITS];
      end
    end
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lut
    pcg_sine_lookup u_lut (
      .clk  (clk),
      .en   (en[3]),
      .quad (quad[i]),
      .idx  (idx[i]),
      .mag  (mag[i]),
      .neg  (neg[i])
    );
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      wave[i] = sine_u16(mag[i], neg[i]);
    end
  end

  // The channel is (sine + 1) / 4, which is the offset wave shifted down by two.
  always_ff @(posedge clk) begin
    if (en[4]) begin
      color.red   <= wave[0][U16_W-1:2];
      color.green <= wave[1][U16_W-1:2];
      color.blue  <= wave[2][U16_W-1:2];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[STAGES-1];

endmodule
